// ===== rtl/mosaic_tile_average_top_macros.svh =====
// Assertion macros shared by the mosaic tile average RTL.
// The enclosing module must provide clk and rst_n.
`ifndef MOSAIC_TILE_AVERAGE_TOP_MACROS_SVH
`define MOSAIC_TILE_AVERAGE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define MTA_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("mosaic tile average: implication check failed");
`define MTA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mosaic tile average: next-cycle check failed");
`else
`define MTA_ASSERT_IMP(name, ante, cons)
`define MTA_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== rtl/mta_pkg.sv =====
package mta_pkg;

    localparam int DEF_MAX_WIDTH = 2048;
    localparam int DEF_MAX_TILE  = 64;
    localparam int HEIGHT_CAP    = 2048;

    localparam int COLOR_W    = 8;
    localparam int COORD_W    = 11;
    localparam int CFG_TILE_W = 7;
    localparam int CFG_IMG_W  = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(3);

    localparam logic [CFG_TILE_W-1:0] RST_TILE_WIDTH   = CFG_TILE_W'(8);
    localparam logic [CFG_TILE_W-1:0] RST_TILE_HEIGHT  = CFG_TILE_W'(8);
    localparam logic [CFG_IMG_W-1:0]  RST_IMAGE_WIDTH  = CFG_IMG_W'(640);
    localparam logic [CFG_IMG_W-1:0]  RST_IMAGE_HEIGHT = CFG_IMG_W'(480);

    typedef enum logic [2:0] {
        DIV_IDLE = 3'b001,
        DIV_RUN  = 3'b010,
        DIV_DONE = 3'b100
    } div_state_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red_in;
        logic [COLOR_W-1:0] green_in;
        logic [COLOR_W-1:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [COLOR_W-1:0] avg_red;
        logic [COLOR_W-1:0] avg_green;
        logic [COLOR_W-1:0] avg_blue;
        logic [COORD_W-1:0] tile_col;
        logic [COORD_W-1:0] tile_row;
        logic               frame_done;
    } tile_avg_t;

endpackage

// ===== rtl/mosaic_tile_average_top.sv =====
// Mosaic tile averager for a raster RGB stream.
// Pixels enter on in_valid/in_stall as one beat each, in raster order; the block
// tracks the position itself. Results leave on out_valid/out_stall, one beat per
// tile, carrying the truncated mean color, the tile column and row, and a flag on
// the last tile of the frame. Edge tiles are clipped and divided by their real area.
// Configuration goes through cfg_en/cfg_index/cfg_data; a write to one of the four
// registers restarts the frame, and a write to any other index is ignored.
// Throughput is one pixel per cycle unless the second stage is held. Per-column
// sums live in one memory, read as a pixel is accepted and written back from the
// second stage, with the last write forwarded. The mean is found by a shared
// divider that yields one quotient bit per cycle for all three colors; a pixel
// that completes a tile waits in the second stage while the divider is busy.
// A result passes from the second stage through the divider into the output
// register. When the receiver stalls, the output register holds its beat,
// the divider holds its finished result and the input side stalls in turn.
// Reset restores the default geometry and restarts at pixel (0,0). The sum memory
// needs no clearing pass, since the first pixel of every tile overwrites its entry.
`include "mosaic_tile_average_top_macros.svh"

module mosaic_tile_average_top
    import mta_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_TILE  = DEF_MAX_TILE
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pixel_t                in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output tile_avg_t             out_data,
    input  logic                  cfg_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int TILE_LIMIT = (2 ** CFG_TILE_W) - 1;
    localparam int TILE_CAP   = (MAX_TILE < TILE_LIMIT) ? MAX_TILE : TILE_LIMIT;
    localparam int CNT_W      = $clog2(TILE_CAP);
    localparam int CP_W       = CNT_W + 1;
    localparam int AREA_W     = 2 * CNT_W + 1;
    localparam int SUM_W      = AREA_W + COLOR_W - 1;
    localparam int IMG_LIMIT  = (2 ** CFG_IMG_W) - 1;
    localparam int WIDTH_CAP  = (MAX_WIDTH < IMG_LIMIT) ? MAX_WIDTH : IMG_LIMIT;
    localparam int X_W        = $clog2(WIDTH_CAP);
    localparam int Y_W        = $clog2(HEIGHT_CAP);
    localparam int TC_W       = CFG_TILE_W + 1;
    localparam int IC_W       = CFG_IMG_W + 1;
    localparam int STEP_W     = $clog2(COLOR_W);
    localparam int MEM_W      = 3 * SUM_W;
    localparam int DEPTH_OF_MEM = WIDTH_CAP;

    localparam logic [CFG_TILE_W-1:0] TILE_CAP_V   = CFG_TILE_W'(TILE_CAP);
    localparam logic [CFG_IMG_W-1:0]  WIDTH_CAP_V  = CFG_IMG_W'(WIDTH_CAP);
    localparam logic [CFG_IMG_W-1:0]  HEIGHT_CAP_V = CFG_IMG_W'(HEIGHT_CAP);
    localparam logic [STEP_W-1:0]     LAST_STEP    = STEP_W'(COLOR_W - 1);

    logic [CFG_TILE_W-1:0] tile_w_reg, tile_h_reg;
    logic [CFG_IMG_W-1:0]  img_w_reg, img_h_reg;
    logic [CFG_TILE_W-1:0] tw_eff, th_eff;
    logic [CFG_IMG_W-1:0]  w_eff, h_eff;

    logic [X_W-1:0]     px_reg, px_next;
    logic [Y_W-1:0]     py_reg, py_next;
    logic [CNT_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   row_reg, row_next;
    logic [X_W-1:0]     tidx_reg, tidx_next;
    logic [COORD_W-1:0] trow_reg, trow_next;

    logic              in_accept, cfg_hit;
    logic              line_end, last_y, frame_end, col_wrap, row_wrap, emit, first;
    logic [CP_W-1:0]   col_p1, row_p1;
    logic [AREA_W-1:0] area;

    logic               s1_valid_reg;
    pixel_t             s1_pix_reg;
    logic [X_W-1:0]     s1_addr_reg;
    logic               s1_first_reg;
    logic               s1_emit_reg;
    logic [AREA_W-1:0]  s1_area_reg;
    logic [COORD_W-1:0] s1_col_reg, s1_row_reg;
    logic               s1_fdone_reg;
    logic               s1_fire;

    logic [MEM_W-1:0] sum_mem [DEPTH_OF_MEM];
    logic [MEM_W-1:0] mem_rdata_reg;
    logic             lw_valid_reg;
    logic [X_W-1:0]   lw_addr_reg;
    logic [MEM_W-1:0] lw_data_reg;
    logic [MEM_W-1:0] old_sums, new_sums;
    logic [SUM_W-1:0] new_sum [3];
    logic [COLOR_W-1:0] pix_c [3];

    div_state_t         div_state_reg, div_state_next;
    logic [STEP_W-1:0]  div_cnt_reg;
    logic [SUM_W-1:0]   div_rem_reg [3];
    logic [SUM_W-1:0]   div_dvs_reg;
    logic [COLOR_W-1:0] div_q_reg [3];
    logic [COORD_W-1:0] div_col_reg, div_row_reg;
    logic               div_fdone_reg;
    logic               div_ge [3];
    logic [SUM_W-1:0]   rem_step [3];
    logic               div_load, out_load;

    logic      out_valid_reg;
    tile_avg_t out_data_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_w_reg <= RST_TILE_WIDTH;
            tile_h_reg <= RST_TILE_HEIGHT;
            img_w_reg  <= RST_IMAGE_WIDTH;
            img_h_reg  <= RST_IMAGE_HEIGHT;
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                REG_TILE_WIDTH:   tile_w_reg <= cfg_data[CFG_TILE_W-1:0];
                REG_TILE_HEIGHT:  tile_h_reg <= cfg_data[CFG_TILE_W-1:0];
                REG_IMAGE_WIDTH:  img_w_reg  <= cfg_data[CFG_IMG_W-1:0];
                REG_IMAGE_HEIGHT: img_h_reg  <= cfg_data[CFG_IMG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        tw_eff = (tile_w_reg == '0) ? CFG_TILE_W'(1) :
                 (tile_w_reg > TILE_CAP_V) ? TILE_CAP_V : tile_w_reg;
        th_eff = (tile_h_reg == '0) ? CFG_TILE_W'(1) :
                 (tile_h_reg > TILE_CAP_V) ? TILE_CAP_V : tile_h_reg;
        w_eff  = (img_w_reg == '0) ? CFG_IMG_W'(1) :
                 (img_w_reg > WIDTH_CAP_V) ? WIDTH_CAP_V : img_w_reg;
        h_eff  = (img_h_reg == '0) ? CFG_IMG_W'(1) :
                 (img_h_reg > HEIGHT_CAP_V) ? HEIGHT_CAP_V : img_h_reg;
    end

    // Position tracking for the pixel being accepted.
    always_comb
    begin
        in_accept = in_valid && !in_stall;
        cfg_hit   = cfg_en && (cfg_index inside {REG_TILE_WIDTH, REG_TILE_HEIGHT,
                                                 REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT});
        line_end  = (IC_W'(px_reg) + IC_W'(1)) >= IC_W'(w_eff);
        last_y    = (IC_W'(py_reg) + IC_W'(1)) >= IC_W'(h_eff);
        frame_end = line_end && last_y;
        col_wrap  = (TC_W'(col_reg) + TC_W'(1)) >= TC_W'(tw_eff);
        row_wrap  = (TC_W'(row_reg) + TC_W'(1)) >= TC_W'(th_eff);
        emit      = (col_wrap || line_end) && (row_wrap || last_y);
        first     = (col_reg == '0) && (row_reg == '0);
        col_p1    = CP_W'(col_reg) + CP_W'(1);
        row_p1    = CP_W'(row_reg) + CP_W'(1);
        area      = AREA_W'(col_p1) * AREA_W'(row_p1);
    end

    always_comb
    begin
        px_next   = px_reg;
        py_next   = py_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        tidx_next = tidx_reg;
        trow_next = trow_reg;
        if (cfg_hit || (in_accept && frame_end))
        begin
            px_next   = '0;
            py_next   = '0;
            col_next  = '0;
            row_next  = '0;
            tidx_next = '0;
            trow_next = '0;
        end
        else if (in_accept && line_end)
        begin
            px_next   = '0;
            col_next  = '0;
            tidx_next = '0;
            py_next   = py_reg + Y_W'(1);
            if (row_wrap)
            begin
                row_next  = '0;
                trow_next = trow_reg + COORD_W'(1);
            end
            else
            begin
                row_next = row_reg + CNT_W'(1);
            end
        end
        else if (in_accept)
        begin
            px_next = px_reg + X_W'(1);
            if (col_wrap)
            begin
                col_next  = '0;
                tidx_next = tidx_reg + X_W'(1);
            end
            else
            begin
                col_next = col_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg   <= '0;
            py_reg   <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
            tidx_reg <= '0;
            trow_reg <= '0;
        end
        else
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            tidx_reg <= tidx_next;
            trow_reg <= trow_next;
        end
    end

    // Second stage: read-modify-write of the column sums.
    assign s1_fire  = s1_valid_reg && (!s1_emit_reg || (div_state_reg == DIV_IDLE));
    assign in_stall = s1_valid_reg && !s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pix_reg   <= in_data;
            s1_addr_reg  <= tidx_reg;
            s1_first_reg <= first;
            s1_emit_reg  <= emit;
            s1_area_reg  <= area;
            s1_col_reg   <= COORD_W'(tidx_reg);
            s1_row_reg   <= trow_reg;
            s1_fdone_reg <= frame_end;
        end
        if (s1_fire)
        begin
            lw_addr_reg <= s1_addr_reg;
            lw_data_reg <= new_sums;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            sum_mem[s1_addr_reg] <= new_sums;
        end
        if (in_accept)
        begin
            mem_rdata_reg <= sum_mem[tidx_reg];
        end
    end

    // The entry written at the read edge is not in the read data, so the last
    // write is forwarded whenever it hits the same column.
    always_comb
    begin
        old_sums = (lw_valid_reg && (lw_addr_reg == s1_addr_reg)) ? lw_data_reg
                                                                   : mem_rdata_reg;
        pix_c[0] = s1_pix_reg.red_in;
        pix_c[1] = s1_pix_reg.green_in;
        pix_c[2] = s1_pix_reg.blue_in;
        for (int ch = 0; ch < 3; ch++)
        begin
            new_sum[ch] = s1_first_reg ? SUM_W'(pix_c[ch])
                                       : old_sums[ch*SUM_W +: SUM_W] + SUM_W'(pix_c[ch]);
        end
        new_sums = {new_sum[2], new_sum[1], new_sum[0]};
    end

    // Shared restoring divider, one quotient bit per cycle for all three colors.
    assign div_load = s1_fire && s1_emit_reg;
    assign out_load = (div_state_reg == DIV_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            div_ge[ch]   = div_rem_reg[ch] >= div_dvs_reg;
            rem_step[ch] = div_ge[ch] ? (div_rem_reg[ch] - div_dvs_reg) : div_rem_reg[ch];
        end
    end

    always_comb
    begin
        div_state_next = div_state_reg;
        case (div_state_reg)
            DIV_IDLE:
            begin
                if (div_load)
                begin
                    div_state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                if (div_cnt_reg == LAST_STEP)
                begin
                    div_state_next = DIV_DONE;
                end
            end
            DIV_DONE:
            begin
                if (out_load)
                begin
                    div_state_next = DIV_IDLE;
                end
            end
            default:
            begin
                div_state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_state_reg <= DIV_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            div_state_reg <= div_state_next;
            if (div_load)
            begin
                div_cnt_reg <= '0;
            end
            else if (div_state_reg == DIV_RUN)
            begin
                div_cnt_reg <= div_cnt_reg + STEP_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_load)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                div_rem_reg[ch] <= new_sum[ch];
                div_q_reg[ch]   <= '0;
            end
            div_dvs_reg   <= SUM_W'(s1_area_reg) << (COLOR_W - 1);
            div_col_reg   <= s1_col_reg;
            div_row_reg   <= s1_row_reg;
            div_fdone_reg <= s1_fdone_reg;
        end
        else if (div_state_reg == DIV_RUN)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                div_rem_reg[ch] <= rem_step[ch];
                div_q_reg[ch]   <= {div_q_reg[ch][COLOR_W-2:0], div_ge[ch]};
            end
            div_dvs_reg <= div_dvs_reg >> 1;
        end
        if (out_load)
        begin
            out_data_reg.avg_red    <= div_q_reg[0];
            out_data_reg.avg_green  <= div_q_reg[1];
            out_data_reg.avg_blue   <= div_q_reg[2];
            out_data_reg.tile_col   <= div_col_reg;
            out_data_reg.tile_row   <= div_row_reg;
            out_data_reg.frame_done <= div_fdone_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `MTA_ASSERT_NEXT(a_s1_holds_when_blocked, s1_valid_reg && !s1_fire, s1_valid_reg && $stable(s1_addr_reg) && $stable(s1_emit_reg))
    `MTA_ASSERT_IMP(a_div_runs_full_width, (div_state_reg == DIV_RUN) && (div_cnt_reg == '0), ##(COLOR_W - 1) (div_state_reg == DIV_RUN) ##1 (div_state_reg == DIV_DONE))
    `MTA_ASSERT_NEXT(a_line_wraps, in_accept && line_end && !cfg_en, (px_reg == '0) && (col_reg == '0) && (tidx_reg == '0))

endmodule
